// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros on clock clk and reset rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle, also checked across reset.
`define ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/drbf_pkg.sv
// ---------------------------------------------------------------------------
// drbf_pkg
// Shared types and constants of the disc rasterizer framebuffer.
// ---------------------------------------------------------------------------
package drbf_pkg;

  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int WORD_BITS         = 32;
  localparam int RADIUS_MIN        = 2;
  localparam int RADIUS_MAX        = 25;
  localparam int SQUARE_SIZE       = 20;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DISC    = 2'd1,
    OP_CHECKER = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
    logic [4:0]  radius;
    logic [13:0] word_index;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_CHK,
    ST_DADJ,
    ST_DROW,
    ST_DRD,
    ST_DWR,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

// File: hdl/drbf_ram.sv
// ---------------------------------------------------------------------------
// drbf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module drbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/drbf_front.sv
// ---------------------------------------------------------------------------
// drbf_front
// Command intake: clamps the radius and queues commands for the back end.
// ---------------------------------------------------------------------------
module drbf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      operation,
  input  logic [9:0]      center_x,
  input  logic [9:0]      center_y,
  input  logic [7:0]      radius,
  input  logic [13:0]     word_index,
  input  logic            busy_init,
  output logic            cmd_valid,
  output drbf_pkg::cmd_t  cmd,
  input  logic            cmd_deq
);
  import drbf_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       enq;
  cmd_t       cmd_in;
  logic [4:0] r_clamped;

  always_comb begin
    if (radius < 8'(RADIUS_MIN)) begin
      r_clamped = 5'(RADIUS_MIN);
    end else if (radius > 8'(RADIUS_MAX)) begin
      r_clamped = 5'(RADIUS_MAX);
    end else begin
      r_clamped = radius[4:0];
    end
    cmd_in.op         = op_t'(operation);
    cmd_in.center_x   = center_x;
    cmd_in.center_y   = center_y;
    cmd_in.radius     = r_clamped;
    cmd_in.word_index = word_index;
  end

  assign full      = (cnt == 2'd2) || busy_init;
  assign enq       = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= ~wp;
      end
      if (cmd_deq) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(enq) - 2'(cmd_deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= cmd_in;
    end
  end

endmodule

// File: hdl/drbf_back.sv
// ---------------------------------------------------------------------------
// drbf_back
// Command sequencer: sweeps, disc row spans with read-modify-write, reads.
// ---------------------------------------------------------------------------
module drbf_back #(
  parameter int SCREEN_WIDTH  = drbf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = drbf_pkg::DEF_SCREEN_HEIGHT,
  parameter int AW            = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  drbf_pkg::cmd_t      cmd,
  output logic                cmd_deq,
  output logic                busy_init,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [31:0]         ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [31:0]         ram_rdata,
  output logic                res_valid,
  output logic [31:0]         read_data,
  input  logic                pop
);
  import drbf_pkg::*;

  localparam int WPR       = (SCREEN_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int STORE     = WPR * SCREEN_HEIGHT;
  localparam int WW        = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int LAST_BITS = SCREEN_WIDTH - (WPR - 1) * WORD_BITS;
  localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (WORD_BITS - LAST_BITS);

  state_t state, state_next;

  logic [AW-1:0] addr;
  logic [WW-1:0] cw;
  logic [4:0]    ym;
  logic          yp;
  logic [4:0]    cm;
  logic          cp;
  logic [9:0]    cx;
  logic [9:0]    cy;
  logic [4:0]    r;
  logic [9:0]    r2;
  logic signed [5:0] dy;
  logic [9:0]    dysq;
  logic [4:0]    h;
  logic [9:0]    xl;
  logic [9:0]    xr;
  logic [4:0]    w;
  logic [AW-1:0] rowbase;
  logic [13:0]   idx;

  logic [5:0]        hp1;
  logic [11:0]       hp1sq;
  logic [9:0]        hsq;
  logic              grow;
  logic              shrink;
  logic signed [11:0] row_y;
  logic signed [11:0] left;
  logic [10:0]       right;
  logic              row_ok;
  logic              span_ok;
  logic [9:0]        xl_c;
  logic [9:0]        xr_c;
  logic [4:0]        lo;
  logic [4:0]        hi;
  logic [31:0]       mask;
  logic [31:0]       chk_data;
  logic [31:0]       col_mask;
  logic [5:0]        cm_sum;
  logic signed [5:0] dyn;
  logic signed [11:0] dyn_sq;
  logic              last_row;
  logic              last_addr;
  logic              rd_ok;
  logic [AW-1:0]     disc_addr;

  always_comb begin
    hp1     = {1'b0, h} + 6'd1;
    hp1sq   = 12'(hp1 * hp1);
    hsq     = 10'(h * h);
    grow    = (hp1sq + {2'b0, dysq}) <= {2'b0, r2};
    shrink  = ({2'b0, hsq} + {2'b0, dysq}) > {2'b0, r2};
    row_y   = $signed({2'b0, cy}) + {{6{dy[5]}}, dy};
    left    = $signed({2'b0, cx}) - $signed({7'b0, h});
    right   = {1'b0, cx} + {6'b0, h};
    row_ok  = !row_y[11] && (row_y[10:0] < 11'(SCREEN_HEIGHT));
    span_ok = left <= $signed(12'(SCREEN_WIDTH - 1));
    xl_c    = left[11] ? 10'd0 : left[9:0];
    xr_c    = (right > 11'(SCREEN_WIDTH - 1)) ? 10'(SCREEN_WIDTH - 1) : right[9:0];
    lo      = (w == xl[9:5]) ? xl[4:0] : 5'd0;
    hi      = (w == xr[9:5]) ? xr[4:0] : 5'd31;
    mask    = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (5'd31 - hi));
    dyn     = dy + 6'sd1;
    dyn_sq  = dyn * dyn;
    last_row  = (dy == $signed({1'b0, r}));
    last_addr = (addr == AW'(STORE - 1));
    rd_ok     = {18'b0, idx} < 32'(STORE);
    disc_addr = rowbase + AW'(w);
    col_mask  = (cw == WW'(WPR - 1)) ? LAST_MASK : 32'hFFFF_FFFF;
    cm_sum    = {1'b0, cm} + 6'(WORD_BITS);
  end

  always_comb begin
    logic [5:0] off;
    logic       p;
    for (int b = 0; b < WORD_BITS; b++) begin
      off         = {1'b0, cm} + 6'(b);
      p           = cp ^ (off >= 6'(SQUARE_SIZE)) ^ (off >= 6'(2 * SQUARE_SIZE));
      chk_data[b] = (p == yp);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT, ST_CLR, ST_CHK: begin
        if (last_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_CLEAR:   state_next = ST_CLR;
            OP_DISC:    state_next = ST_DADJ;
            OP_CHECKER: state_next = ST_CHK;
            OP_READ:    state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DADJ: begin
        if (!grow && !shrink) begin
          state_next = ST_DROW;
        end
      end
      ST_DROW: begin
        if (row_ok && span_ok) begin
          state_next = ST_DRD;
        end else if (last_row) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DADJ;
        end
      end
      ST_DRD: state_next = ST_DWR;
      ST_DWR: begin
        if (w != xr[9:5]) begin
          state_next = ST_DRD;
        end else if (last_row) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DADJ;
        end
      end
      ST_READ: state_next = ST_RESP;
      ST_RESP: begin
        if (!res_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_deq   = 1'b0;
    busy_init = (state == ST_INIT);
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = 32'd0;
    ram_re    = 1'b0;
    ram_raddr = disc_addr;
    case (state)
      ST_INIT, ST_CLR: begin
        ram_we = 1'b1;
      end
      ST_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = chk_data & col_mask;
      end
      ST_IDLE: begin
        cmd_deq = cmd_valid;
      end
      ST_DRD: begin
        ram_re = 1'b1;
      end
      ST_DWR: begin
        ram_we    = 1'b1;
        ram_waddr = disc_addr;
        ram_wdata = ram_rdata | mask;
      end
      ST_READ: begin
        ram_re    = rd_ok;
        ram_raddr = AW'(idx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      addr      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        addr <= '0;
      end else if (state == ST_INIT || state == ST_CLR || state == ST_CHK) begin
        addr <= addr + AW'(1);
      end
      if (state == ST_RESP && !res_valid) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cx   <= cmd.center_x;
        cy   <= cmd.center_y;
        r    <= cmd.radius;
        r2   <= 10'(cmd.radius * cmd.radius);
        dysq <= 10'(cmd.radius * cmd.radius);
        dy   <= -$signed({1'b0, cmd.radius});
        h    <= 5'd0;
        idx  <= cmd.word_index;
        cw   <= '0;
        ym   <= 5'd0;
        yp   <= 1'b0;
        cm   <= 5'd0;
        cp   <= 1'b0;
      end
      ST_CHK: begin
        if (cw == WW'(WPR - 1)) begin
          cw <= '0;
          cm <= 5'd0;
          cp <= 1'b0;
          if (ym == 5'(SQUARE_SIZE - 1)) begin
            ym <= 5'd0;
            yp <= ~yp;
          end else begin
            ym <= ym + 5'd1;
          end
        end else begin
          cw <= cw + WW'(1);
          if (cm_sum >= 6'(2 * SQUARE_SIZE)) begin
            cm <= 5'(cm_sum - 6'(2 * SQUARE_SIZE));
          end else begin
            cm <= 5'(cm_sum - 6'(SQUARE_SIZE));
            cp <= ~cp;
          end
        end
      end
      ST_DADJ: begin
        if (grow) begin
          h <= h + 5'd1;
        end else if (shrink) begin
          h <= h - 5'd1;
        end
      end
      ST_DROW: begin
        if (row_ok && span_ok) begin
          xl      <= xl_c;
          xr      <= xr_c;
          w       <= xl_c[9:5];
          rowbase <= AW'(32'(row_y[9:0]) * WPR);
        end else begin
          dy   <= dyn;
          dysq <= dyn_sq[9:0];
        end
      end
      ST_DWR: begin
        if (w == xr[9:5]) begin
          dy   <= dyn;
          dysq <= dyn_sq[9:0];
        end else begin
          w <= w + 5'd1;
        end
      end
      ST_RESP: begin
        if (!res_valid) begin
          read_data <= rd_ok ? ram_rdata : 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/disc_rasterizer_bit_framebuffer_unit.sv
// ---------------------------------------------------------------------------
// disc_rasterizer_bit_framebuffer_unit
// One-bit-per-pixel framebuffer with clear, filled disc, checkerboard, read.
// ---------------------------------------------------------------------------
// Commands enter through a queue port (push/full) into a two-entry command
// queue; read results leave through a queue port (empty/pop) holding one word.
// Each command is a transaction on the push side; read word yields exactly
// one transaction on the result side, other commands yield none.
// Sequencing, with S = ceil(SCREEN_WIDTH/32) * SCREEN_HEIGHT store words:
//   clear and checkerboard: all S words, one word written per cycle.
//   read word: a read state, then a response state that registers the word
//   and drops empty once the previous result has been popped.
//   disc: per row an adjust and a row setup step, then a read and a write step
//   per word (read-modify-write on the single RAM port pair), plus radius steps.
// After reset the whole store is swept to zero with full high.
// When the result is not popped the sequencer holds on the next read word,
// while the command queue keeps taking transactions until it fills.
// ---------------------------------------------------------------------------
module disc_rasterizer_bit_framebuffer_unit #(
  parameter int SCREEN_WIDTH  = drbf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = drbf_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [9:0]  center_x,
  input  logic [9:0]  center_y,
  input  logic [7:0]  radius,
  input  logic [13:0] word_index,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] read_data
);
  import drbf_pkg::*;

  localparam int WPR   = (SCREEN_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int STORE = WPR * SCREEN_HEIGHT;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

  logic          busy_init;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_deq;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic          res_valid;

  drbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .word_index (word_index),
    .busy_init  (busy_init),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_deq    (cmd_deq)
  );

  drbf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .AW            (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_deq   (cmd_deq),
    .busy_init (busy_init),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .read_data (read_data),
    .pop       (pop)
  );

  drbf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign empty = !res_valid;

endmodule

// File: hdl/drbf_checker.sv
// ---------------------------------------------------------------------------
// drbf_checker
// Port-level checks of the framebuffer unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module drbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [31:0] read_data
);

  // result holds until taken
  `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(read_data), "result dropped or changed")
  // one result slot: a pop empties it, so empty is high in the cycle after
  `ASSERT_NEXT(a_pop_drain, !empty && pop, empty, "result slot refilled on pop")
  // store clear sweep after reset blocks input
  `ASSERT_NEXT_ANY(a_rst_full, rst, full && empty, "input open or result shown after reset")

endmodule

bind disc_rasterizer_bit_framebuffer_unit drbf_checker u_drbf_checker (.*);

// File: sim/drbf_checker.sv
// ----------------------------------------------------------------------------
// drbf_scoreboard
// Watches both queue ports of the framebuffer unit, keeps a shadow framebuffer
// updated on every accepted command, and compares every popped read word
// against the oldest predicted word.
// ----------------------------------------------------------------------------
module drbf_scoreboard #(
  parameter int SCREEN_WIDTH  = drbf_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = drbf_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  operation,
  input  logic [9:0]  center_x,
  input  logic [9:0]  center_y,
  input  logic [7:0]  radius,
  input  logic [13:0] word_index,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] read_data,
  output int          mismatches,
  output int          words_pending
);
  import drbf_pkg::*;

  localparam int ROW_WORDS   = (SCREEN_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int STORE_WORDS = ROW_WORDS * SCREEN_HEIGHT;

  bit [31:0] shadow_fb [STORE_WORDS];
  bit [31:0] read_words_q [$];

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  task automatic mark_pixel(input int col, input int row, input bit lit);
    int addr;
    if (col < 0 || row < 0 || col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return;
    addr = row * ROW_WORDS + col / WORD_BITS;
    shadow_fb[addr][col % WORD_BITS] = lit;
  endtask

  task automatic paint_disc(input int cx, input int cy, input int r_req);
    int r;
    r = r_req;
    if (r < RADIUS_MIN) r = RADIUS_MIN;
    if (r > RADIUS_MAX) r = RADIUS_MAX;
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        if (dx * dx + dy * dy <= r * r) mark_pixel(cx + dx, cy + dy, 1'b1);
  endtask

  task automatic paint_checker();
    for (int row = 0; row < SCREEN_HEIGHT; row++)
      for (int col = 0; col < SCREEN_WIDTH; col++)
        mark_pixel(col, row, ((row / SQUARE_SIZE) & 1) == ((col / SQUARE_SIZE) & 1));
  endtask

  always @(posedge clk) begin
    bit [31:0] want;
    if (!rst) begin
      if (push && !full) begin
        case (op_t'(operation))
          OP_CLEAR: begin
            for (int i = 0; i < STORE_WORDS; i++) shadow_fb[i] = '0;
          end
          OP_DISC:    paint_disc(center_x, center_y, radius);
          OP_CHECKER: paint_checker();
          OP_READ: begin
            read_words_q.push_back(word_index < STORE_WORDS ? shadow_fb[word_index] : '0);
          end
          default: begin
          end
        endcase
      end
      if (pop && !empty) begin
        if (read_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected read transaction, read_data=%h", $realtime, read_data);
        end else begin
          want = read_words_q.pop_front();
          if (read_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: read_data mismatch: expected %h, actual %h",
                       $realtime, want, read_data);
          end
        end
      end
      words_pending = read_words_q.size();
    end
  end
endmodule

// File: sim/tb_disc_rasterizer_bit_framebuffer_unit.sv
// ----------------------------------------------------------------------------
// tb_disc_rasterizer_bit_framebuffer_unit
// Drives directed then random clear, disc, checkerboard and read commands with
// random idle bursts on both ports; the checker predicts and compares words.
// ----------------------------------------------------------------------------
module tb_disc_rasterizer_bit_framebuffer_unit;
  import drbf_pkg::*;

  localparam int ITEMS       = 600;
  localparam int QUIET_ITEMS = 100;
  localparam int STALL_LIMIT = 100000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  operation;
  logic [9:0]  center_x;
  logic [9:0]  center_y;
  logic [7:0]  radius;
  logic [13:0] word_index;
  logic        empty;
  logic        pop;
  logic [31:0] read_data;
  int          mismatches;
  int          words_pending;
  bit          quiet;
  int          idle_cycles;
  int          last_cx;
  int          last_cy;

  disc_rasterizer_bit_framebuffer_unit dut (.*);

  drbf_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog: cycles with no transaction on either port
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int stall;
    pop   = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 8);
      end else pop <= 1'b1;
    end
  end

  task automatic send_cmd(input op_t op, input int cx, input int cy, input int r,
                          input int idx);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push       <= 1'b1;
    operation  <= op;
    center_x   <= 10'(cx);
    center_y   <= 10'(cy);
    radius     <= 8'(r);
    word_index <= 14'(idx);
    do @(posedge clk); while (full);
  endtask

  task automatic send_random(input bit force_read);
    int pick;
    int cx;
    int cy;
    int idx;
    pick = force_read ? 99 : $urandom_range(0, 99);
    if (pick < 3) send_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 6) send_cmd(OP_CHECKER, $urandom, $urandom, $urandom, $urandom);
    else if (pick < 50) begin
      if ($urandom_range(0, 4) == 0) begin
        cx = $urandom_range(0, 1023);
        cy = $urandom_range(0, 1023);
      end else begin
        cx = $urandom_range(0, 670);
        cy = $urandom_range(0, 510);
      end
      last_cx = cx;
      last_cy = cy;
      send_cmd(OP_DISC, cx, cy, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 30),
               $urandom);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        cx  = last_cx + $urandom_range(0, 60) - 30;
        cy  = last_cy + $urandom_range(0, 60) - 30;
        if (cx < 0) cx = 0;
        if (cy < 0) cy = 0;
        idx = (cy * 20 + cx / 32) % 16384;
      end else if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 16383);
      else idx = $urandom_range(0, 9599);
      send_cmd(OP_READ, $urandom, $urandom, $urandom, idx);
    end
  endtask

  initial begin
    quiet      = 1'b0;
    push       = 1'b0;
    operation  = '0;
    center_x   = '0;
    center_y   = '0;
    radius     = '0;
    word_index = '0;
    idle_cycles = 0;
    last_cx    = 320;
    last_cy    = 240;
    @(negedge rst);
    @(posedge clk);
    send_cmd(OP_READ, 0, 0, 0, 0);
    send_cmd(OP_DISC, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0);
    send_cmd(OP_DISC, 639, 479, 1, 0);
    send_cmd(OP_READ, 0, 0, 0, 9599);
    send_cmd(OP_DISC, 320, 240, 255, 0);
    send_cmd(OP_READ, 0, 0, 0, 240 * 20 + 10);
    send_cmd(OP_READ, 0, 0, 0, 215 * 20 + 10);
    send_cmd(OP_DISC, 1023, 1023, 26, 16383);
    send_cmd(OP_DISC, 650, 100, 25, 0);
    send_cmd(OP_READ, 0, 0, 0, 100 * 20 + 19);
    send_cmd(OP_READ, 0, 0, 0, 9600);
    send_cmd(OP_READ, 0, 0, 0, 16383);
    send_cmd(OP_CHECKER, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 20 * 20 + 1);
    send_cmd(OP_DISC, 100, 100, 2, 0);
    send_cmd(OP_READ, 0, 0, 0, 100 * 20 + 3);
    send_cmd(OP_CLEAR, 1023, 1023, 255, 16383);
    send_cmd(OP_READ, 0, 0, 0, 100 * 20 + 3);
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_random(i == ITEMS - 1);
    end
    push <= 1'b0;
    @(posedge clk);
    while (words_pending != 0 || !empty) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
